/* hdl/rar_pkg.sv */
// Shared types and constants for the rational arithmetic reduce unit.
package rar_pkg;
   localparam int OperandWidthDefault = 32;
   localparam int MagWidth = 64;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE,
      ST_GCD_START,
      ST_GCD_WAIT,
      ST_DIVN_START,
      ST_DIVN_WAIT,
      ST_DIVD_START,
      ST_DIVD_WAIT,
      ST_DONE
   } state_type;
endpackage

/* hdl/rar_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned 64-bit operands.
module rar_divider import rar_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MagWidth-1:0] dividend,
   input  logic [MagWidth-1:0] divisor,
   output logic                busy,
   output logic [MagWidth-1:0] quotient,
   output logic [MagWidth-1:0] remainder
);
   localparam int CntWidth = $clog2(MagWidth + 1);

   logic [MagWidth-1:0] quo_ff, quo_in;
   logic [MagWidth-1:0] rem_ff, rem_in;
   logic [MagWidth-1:0] dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [MagWidth:0]   trial;
   logic [MagWidth:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[MagWidth-1]};
      diff = trial - {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CntWidth'(MagWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!diff[MagWidth]) begin
            rem_in = diff[MagWidth-1:0];
            quo_in = {quo_ff[MagWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[MagWidth-1:0];
            quo_in = {quo_ff[MagWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

/* hdl/rational_arith_reduce_unit.sv */
// Top level of the rational arithmetic reduce unit.
//
// Takes one request word (cmd, a_num/a_den, b_num/b_den) on the req_ channel
// and returns one response word on the rsp_ channel: the reduced fraction with
// the sign on the numerator, a whole-number flag and a zero-denominator status.
// Operands are read as OPERAND_WIDTH-bit two's complement values.
//
// The raw terms come from one shared 32x32 multiplier in states MUL0, MUL1 and
// MUL2. The gcd runs Euclid's loop on a shared bit-serial divider, then the
// same divider makes two exact divisions. Zero numerator or denominator skips
// the gcd and the divisions and goes straight to a valid response.
// One word is in flight at a time; req_stall is high from acceptance until the
// response is taken. A stalled response holds its payload.
// Reset clears the sequencer and drops any word in flight.
module rational_arith_reduce_unit import rar_pkg::*; #(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_res_num,
   output logic [62:0]        rsp_res_den,
   output logic               rsp_is_whole,
   output logic               rsp_status
);
   localparam int OpW = OPERAND_WIDTH;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic [OpW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [OpW-1:0] mx, my;
   logic [MagWidth-1:0] prod;
   logic           mneg;
   logic [MagWidth-1:0] p0_ff, p1_ff, dm_ff, nm_ff, gx_ff, gy_ff, g_ff;
   logic p0n_ff, p1n_ff, dn_ff, nn_ff;
   logic [MagWidth-1:0] resn_ff;
   logic                div_start, div_busy;
   logic [MagWidth-1:0] div_a, div_b, div_q, div_r;
   logic [MagWidth-1:0] sum;
   logic [MagWidth-1:0] num_raw;
   logic                sum_neg, q_neg;

   function automatic logic [OpW-1:0] mag(input logic [OpW-1:0] v);
      return v[OpW-1] ? (~v + 1'b1) : v;
   endfunction

   // shared multiplier on magnitudes
   always_comb begin
      unique case (state_ff)
         ST_MUL0: begin
            mx = an_ff;
            my = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         ST_MUL1: begin
            mx = bn_ff;
            my = ad_ff;
         end
         default: begin
            mx = ad_ff;
            my = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
         end
      endcase
      prod = MagWidth'(mag(mx)) * MagWidth'(mag(my));
      mneg = (mx[OpW-1] ^ my[OpW-1]) && (prod != '0);
   end

   // sign-magnitude add of the two cross terms
   always_comb begin
      q_neg = (cmd_ff == CMD_SUB) ? (!p1n_ff && p1_ff != '0) : p1n_ff;
      if (p0n_ff == q_neg) begin
         sum = p0_ff + p1_ff;
         sum_neg = p0n_ff;
      end else if (p0_ff >= p1_ff) begin
         sum = p0_ff - p1_ff;
         sum_neg = p0n_ff && (p0_ff != p1_ff);
      end else begin
         sum = p1_ff - p0_ff;
         sum_neg = q_neg;
      end
      num_raw = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) ? sum : p0_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_MUL0;
         ST_MUL0:      state_in = ST_MUL1;
         ST_MUL1:      state_in = ST_MUL2;
         ST_MUL2:      state_in = ST_COMBINE;
         ST_COMBINE:   state_in = (dm_ff == '0 || num_raw == '0) ? ST_DONE : ST_GCD_START;
         ST_GCD_START: state_in = (gy_ff == '0) ? ST_DIVN_START : ST_GCD_WAIT;
         ST_GCD_WAIT:  if (!div_busy) state_in = ST_GCD_START;
         ST_DIVN_START: state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: if (!div_busy) state_in = ST_DIVD_START;
         ST_DIVD_START: state_in = ST_DIVD_WAIT;
         ST_DIVD_WAIT: if (!div_busy) state_in = ST_DONE;
         ST_DONE:      if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_a = gx_ff;
      div_b = gy_ff;
      unique case (state_ff)
         ST_GCD_START:  div_start = (gy_ff != '0);
         ST_DIVN_START: begin
            div_start = 1'b1;
            div_a = nm_ff;
            div_b = g_ff;
         end
         ST_DIVD_START: begin
            div_start = 1'b1;
            div_a = dm_ff;
            div_b = g_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   rar_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .busy(div_busy), .quotient(div_q), .remainder(div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff <= cmd_type'(req_cmd);
            an_ff <= req_a_num[OpW-1:0];
            ad_ff <= req_a_den[OpW-1:0];
            bn_ff <= req_b_num[OpW-1:0];
            bd_ff <= req_b_den[OpW-1:0];
         end
         ST_MUL0: begin
            p0_ff <= prod;
            p0n_ff <= mneg;
         end
         ST_MUL1: begin
            p1_ff <= prod;
            p1n_ff <= mneg;
         end
         ST_MUL2: begin
            dm_ff <= prod;
            dn_ff <= mneg;
         end
         ST_COMBINE: begin
            if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
               nm_ff <= sum;
               nn_ff <= sum_neg;
               gx_ff <= sum;
            end else begin
               nm_ff <= p0_ff;
               nn_ff <= p0n_ff;
               gx_ff <= p0_ff;
            end
            gy_ff <= dm_ff;
         end
         ST_GCD_START: g_ff <= gx_ff;
         ST_GCD_WAIT: if (!div_busy) begin
            // advance Euclid: (x, y) <= (y, x mod y)
            gx_ff <= gy_ff;
            gy_ff <= div_r;
         end
         ST_DIVN_WAIT: if (!div_busy) resn_ff <= div_q;
         ST_DIVD_WAIT: if (!div_busy) dm_ff <= div_q;
         default: ;
      endcase
   end

   logic [MagWidth-1:0] sat;
   logic zero_den, zero_num;
   always_comb begin
      zero_den = (dm_ff == '0);
      zero_num = (nm_ff == '0);
      sat = resn_ff[MagWidth-1] ? {1'b0, {(MagWidth-1){1'b1}}} : resn_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      rsp_status = zero_den;
      if (zero_den) begin
         rsp_res_num = '0;
         rsp_res_den = '0;
         rsp_is_whole = 1'b0;
      end else if (zero_num) begin
         rsp_res_num = '0;
         rsp_res_den = 63'd1;
         rsp_is_whole = 1'b1;
      end else begin
         rsp_res_num = (nn_ff != dn_ff) ? -$signed(sat) : $signed(sat);
         rsp_res_den = dm_ff[62:0];
         rsp_is_whole = (dm_ff == 64'd1);
      end
   end
endmodule
